// ===== hw/rtl/gbw_pkg.sv =====
// Shared types, access codes and tap weights for the 3x3 RGB blur block.
`default_nettype none
package gbw_pkg;

  typedef logic [1:0]  func_t;
  typedef logic [1:0]  status_t;
  typedef logic [7:0]  pix_t;
  typedef logic [2:0]  lanes_t;
  typedef logic [3:0]  tap_t;
  typedef logic [13:0] weight_t;
  typedef logic [23:0] sum_t;
  typedef logic [1:0]  bank_t;

  // access codes
  localparam func_t FN_WRITE = 2'd0;
  localparam func_t FN_READ  = 2'd1;
  localparam func_t FN_COUNT = 2'd2;
  localparam func_t FN_BAD   = 2'd3;

  // status codes
  localparam status_t ST_OK    = 2'd0;
  localparam status_t ST_ERR   = 2'd1;
  localparam status_t ST_BUSY  = 2'd2;
  localparam status_t ST_EMPTY = 2'd3;

  localparam lanes_t LANES_ALL = 3'b111;
  localparam tap_t   TAP_LAST  = 4'd8;

  // one bank per color; a window lands as one row across the three banks
  localparam int    NUM_BANKS = 3;
  localparam bank_t BANK_R    = 2'd0;
  localparam bank_t BANK_G    = 2'd1;
  localparam bank_t BANK_B    = 2'd2;

  localparam weight_t W_CORNER = 14'd5102;
  localparam weight_t W_EDGE   = 14'd8082;
  localparam weight_t W_CENTER = 14'd12802;

  // Q0.16 kernel weight by tap, column-major
  function automatic weight_t tap_weight(input tap_t tap);
    weight_t w;
    case (tap)
      4'd0, 4'd2, 4'd6, 4'd8: w = W_CORNER;
      4'd4:                   w = W_CENTER;
      default:                w = W_EDGE;
    endcase
    return w;
  endfunction

endpackage
`default_nettype wire

// ===== hw/rtl/gbw_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
`default_nettype none
module gbw_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 4
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule
`default_nettype wire

// ===== hw/rtl/gaussian_blur_window_rgb.sv =====
// Top level: 3x3 Gaussian blur over RGB pixel windows with a banked result queue.
// Each word's response is registered: it is valid in the cycle after the word is accepted.
// Throughput: one word per cycle while out_ready is high or no response is held; one
//   constant-weight MAC per color per write feeds the accumulators.
// Pops read the queue RAMs on acceptance; the RAM output register is the response.
// Reset (sync, active low) clears tap index, sums, queue pointers and count;
//   queue storage is not cleared.
`default_nettype none
module gaussian_blur_window_rgb #(
  parameter int RESULT_DEPTH = 8
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             in_valid,
  output logic             in_ready,
  input  gbw_pkg::func_t   in_func,
  input  gbw_pkg::pix_t    in_red,
  input  gbw_pkg::pix_t    in_green,
  input  gbw_pkg::pix_t    in_blue,
  input  gbw_pkg::lanes_t  in_lane_enables,
  output logic             out_valid,
  input  logic             out_ready,
  output gbw_pkg::pix_t    out_read_data,
  output gbw_pkg::status_t out_status
);
  import gbw_pkg::*;

  localparam int CNT_W = $clog2(RESULT_DEPTH + 1);
  // enough rows that live entries never alias across a wrap
  localparam int ROWS  = RESULT_DEPTH / 3 + 2;
  localparam int ROW_W = $clog2(ROWS);
  localparam logic [CNT_W-1:0] FILL_MAX_WIN = CNT_W'(RESULT_DEPTH - 3);
  localparam logic [ROW_W-1:0] ROW_LAST     = ROW_W'(ROWS - 1);

  logic             in_fire;
  logic             out_valid_r, out_valid_nxt;
  tap_t             tap_r, tap_nxt;
  sum_t             sum_red_r, sum_red_nxt;
  sum_t             sum_green_r, sum_green_nxt;
  sum_t             sum_blue_r, sum_blue_nxt;
  logic [CNT_W-1:0] fill_r, fill_nxt;
  logic [ROW_W-1:0] wr_row_r, wr_row_nxt;
  logic [ROW_W-1:0] rd_row_r, rd_row_nxt;
  bank_t            rd_bank_r, rd_bank_nxt;
  pix_t             data_r, data_nxt;
  status_t          status_r, status_nxt;
  logic             pop_r;
  bank_t            pop_bank_r;
  logic             push, pop;
  weight_t          weight;
  logic [21:0]      prod_red, prod_green, prod_blue;
  sum_t             acc_red, acc_green, acc_blue;
  pix_t             push_data [NUM_BANKS];
  pix_t             bank_rdata [NUM_BANKS];
  pix_t             pop_data;

  assign in_ready = !out_valid_r || out_ready;
  assign in_fire  = in_valid && in_ready;

  assign weight     = tap_weight(tap_r);
  assign prod_red   = in_red * weight;
  assign prod_green = in_green * weight;
  assign prod_blue  = in_blue * weight;
  assign acc_red    = sum_red_r + sum_t'(prod_red);
  assign acc_green  = sum_green_r + sum_t'(prod_green);
  assign acc_blue   = sum_blue_r + sum_t'(prod_blue);

  assign push_data[BANK_R] = acc_red[23:16];
  assign push_data[BANK_G] = acc_green[23:16];
  assign push_data[BANK_B] = acc_blue[23:16];

  always_comb begin
    tap_nxt       = tap_r;
    sum_red_nxt   = sum_red_r;
    sum_green_nxt = sum_green_r;
    sum_blue_nxt  = sum_blue_r;
    fill_nxt      = fill_r;
    wr_row_nxt    = wr_row_r;
    rd_row_nxt    = rd_row_r;
    rd_bank_nxt   = rd_bank_r;
    data_nxt      = '0;
    status_nxt    = ST_OK;
    push          = 1'b0;
    pop           = 1'b0;
    if (in_fire) begin
      case (in_func)
        FN_WRITE: begin
          if (in_lane_enables != LANES_ALL) begin
            status_nxt = ST_ERR;
          end else if (tap_r == TAP_LAST && fill_r > FILL_MAX_WIN) begin
            status_nxt = ST_BUSY;
          end else if (tap_r == TAP_LAST) begin
            push          = 1'b1;
            wr_row_nxt    = (wr_row_r == ROW_LAST) ? '0 : wr_row_r + 1'b1;
            fill_nxt      = fill_r + CNT_W'(3);
            sum_red_nxt   = '0;
            sum_green_nxt = '0;
            sum_blue_nxt  = '0;
            tap_nxt       = '0;
          end else begin
            sum_red_nxt   = acc_red;
            sum_green_nxt = acc_green;
            sum_blue_nxt  = acc_blue;
            tap_nxt       = tap_r + 1'b1;
          end
        end
        FN_READ: begin
          if (fill_r == '0) begin
            status_nxt = ST_EMPTY;
          end else begin
            pop      = 1'b1;
            fill_nxt = fill_r - 1'b1;
            if (rd_bank_r == BANK_B) begin
              rd_bank_nxt = BANK_R;
              rd_row_nxt  = (rd_row_r == ROW_LAST) ? '0 : rd_row_r + 1'b1;
            end else begin
              rd_bank_nxt = rd_bank_r + 1'b1;
            end
          end
        end
        FN_COUNT: data_nxt = pix_t'(fill_r);
        default:  status_nxt = ST_ERR;
      endcase
    end
  end

  assign out_valid_nxt = in_fire || (out_valid_r && !out_ready);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
      tap_r       <= '0;
      sum_red_r   <= '0;
      sum_green_r <= '0;
      sum_blue_r  <= '0;
      fill_r      <= '0;
      wr_row_r    <= '0;
      rd_row_r    <= '0;
      rd_bank_r   <= BANK_R;
    end else begin
      out_valid_r <= out_valid_nxt;
      tap_r       <= tap_nxt;
      sum_red_r   <= sum_red_nxt;
      sum_green_r <= sum_green_nxt;
      sum_blue_r  <= sum_blue_nxt;
      fill_r      <= fill_nxt;
      wr_row_r    <= wr_row_nxt;
      rd_row_r    <= rd_row_nxt;
      rd_bank_r   <= rd_bank_nxt;
    end
  end

  // response word; pop data comes straight from the RAM read register
  always_ff @(posedge clk) begin
    if (in_fire) begin
      data_r     <= data_nxt;
      status_r   <= status_nxt;
      pop_r      <= pop;
      pop_bank_r <= rd_bank_r;
    end
  end

  for (genvar b = 0; b < NUM_BANKS; b++) begin : g_bank
    gbw_ram #(
      .WIDTH ($bits(pix_t)),
      .DEPTH (ROWS)
    ) u_ram (
      .clk   (clk),
      .we    (push),
      .waddr (wr_row_r),
      .wdata (push_data[b]),
      .re    (pop && rd_bank_r == bank_t'(b)),
      .raddr (rd_row_r),
      .rdata (bank_rdata[b])
    );
  end

  always_comb begin
    case (pop_bank_r)
      BANK_R:  pop_data = bank_rdata[BANK_R];
      BANK_G:  pop_data = bank_rdata[BANK_G];
      default: pop_data = bank_rdata[BANK_B];
    endcase
  end

  assign out_valid     = out_valid_r;
  assign out_read_data = pop_r ? pop_data : data_r;
  assign out_status    = status_r;

`ifndef SYNTHESIS
  a_fill_bound: assert property (@(posedge clk) disable iff (!rst_n)
    fill_r <= CNT_W'(RESULT_DEPTH))
    else $error("result queue count above depth");

  a_tap_bound: assert property (@(posedge clk) disable iff (!rst_n)
    tap_r <= TAP_LAST)
    else $error("tap index past last tap");

  a_pop_count: assert property (@(posedge clk) disable iff (!rst_n)
    (in_fire && in_func == FN_READ && fill_r != '0) |=> fill_r == $past(fill_r) - 1'b1)
    else $error("pop did not drop queue count");

  a_busy_tap: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && status_r == ST_BUSY) |-> tap_r == TAP_LAST)
    else $error("busy response without a held last tap");

  a_push_room: assert property (@(posedge clk) disable iff (!rst_n)
    push |-> fill_r <= FILL_MAX_WIN)
    else $error("window pushed without three free slots");
`endif

endmodule
`default_nettype wire

// ===== dv/tb.sv =====
// Self-checking testbench for the 3x3 RGB Gaussian blur block.
`default_nettype none
module tb;
  timeunit 1ns;
  timeprecision 1ps;

  import gbw_pkg::*;

  localparam int DEPTH = 8;

  typedef struct packed {
    pix_t    data;
    status_t status;
  } resp_t;

  logic    clk = 1'b0;
  logic    rst_n = 1'b0;
  logic    in_valid = 1'b0;
  logic    in_ready;
  func_t   in_func = FN_COUNT;
  pix_t    in_red = '0;
  pix_t    in_green = '0;
  pix_t    in_blue = '0;
  lanes_t  in_lane_enables = '0;
  logic    out_valid;
  logic    out_ready = 1'b0;
  pix_t    out_read_data;
  status_t out_status;

  // predictor state
  tap_t    tap_idx;
  sum_t    acc_red, acc_green, acc_blue;
  pix_t    blur_fifo[$];
  resp_t   pending_resp[$];
  resp_t   want;

  bit      calm = 1'b0;
  int      errors = 0;
  int      words_sent = 0;

  gaussian_blur_window_rgb #(.RESULT_DEPTH(DEPTH)) u_top (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_valid),
    .in_ready       (in_ready),
    .in_func        (in_func),
    .in_red         (in_red),
    .in_green       (in_green),
    .in_blue        (in_blue),
    .in_lane_enables(in_lane_enables),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .out_read_data  (out_read_data),
    .out_status     (out_status)
  );

  always #10 clk = ~clk;

  initial begin
    #5_000_000;
    $display("gaussian_blur_window_rgb verification failed");
    $finish;
  end

  function automatic pix_t rnd_pix();
    return pix_t'($urandom);
  endfunction

  function automatic lanes_t rnd_lanes();
    return lanes_t'($urandom);
  endfunction

  // Q0.16 weight: corners have no middle coordinate, center has two
  function automatic int unsigned kernel_weight(input tap_t t);
    int unsigned col;
    int unsigned row;
    int unsigned mids;
    col = t / 3;
    row = t % 3;
    mids = (row == 1) + (col == 1);
    case (mids)
      0:       return 32'(W_CORNER);
      1:       return 32'(W_EDGE);
      default: return 32'(W_CENTER);
    endcase
  endfunction

  task automatic predict_word(input func_t f, input pix_t r, input pix_t g, input pix_t b,
                              input lanes_t le);
    resp_t       rsp;
    int unsigned w;
    rsp = '{data: '0, status: ST_OK};
    case (f)
      FN_WRITE: begin
        if (le != LANES_ALL) begin
          rsp.status = ST_ERR;
        end else if (tap_idx == TAP_LAST && DEPTH - blur_fifo.size() < 3) begin
          rsp.status = ST_BUSY;
        end else begin
          w = kernel_weight(tap_idx);
          acc_red   = sum_t'(32'(acc_red) + r * w);
          acc_green = sum_t'(32'(acc_green) + g * w);
          acc_blue  = sum_t'(32'(acc_blue) + b * w);
          if (tap_idx == TAP_LAST) begin
            blur_fifo.push_back(acc_red[23:16]);
            blur_fifo.push_back(acc_green[23:16]);
            blur_fifo.push_back(acc_blue[23:16]);
            acc_red = '0;
            acc_green = '0;
            acc_blue = '0;
            tap_idx = '0;
          end else begin
            tap_idx = tap_idx + 1'b1;
          end
        end
      end
      FN_READ: begin
        if (blur_fifo.size() == 0) rsp.status = ST_EMPTY;
        else rsp.data = blur_fifo.pop_front();
      end
      FN_COUNT: rsp.data = pix_t'(blur_fifo.size());
      default:  rsp.status = ST_ERR;
    endcase
    pending_resp.push_back(rsp);
  endtask

  task automatic send_word(input func_t f, input pix_t r, input pix_t g, input pix_t b,
                           input lanes_t le);
    while (!calm && $urandom_range(99) < 31) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid        <= 1'b1;
    in_func         <= f;
    in_red          <= r;
    in_green        <= g;
    in_blue         <= b;
    in_lane_enables <= le;
    do @(posedge clk); while (!(in_valid && in_ready));
    predict_word(f, r, g, b, le);
    if (!(f == FN_BAD || (f == FN_WRITE && le != LANES_ALL))) words_sent++;
  endtask

  task automatic wait_drained();
    in_valid <= 1'b0;
    do @(posedge clk); while (pending_resp.size() != 0);
  endtask

  task automatic send_noise();
    case ($urandom_range(2))
      0:       send_word(FN_BAD, rnd_pix(), rnd_pix(), rnd_pix(), rnd_lanes());
      1:       send_word(FN_WRITE, rnd_pix(), rnd_pix(), rnd_pix(),
                         lanes_t'($urandom_range(6)));
      default: send_word(FN_COUNT, rnd_pix(), rnd_pix(), rnd_pix(), rnd_lanes());
    endcase
  endtask

  task automatic send_window(input int noise_pct);
    repeat (9) begin
      if ($urandom_range(99) < noise_pct) send_noise();
      send_word(FN_WRITE, rnd_pix(), rnd_pix(), rnd_pix(), LANES_ALL);
    end
  endtask

  task automatic send_reads(input int n);
    repeat (n) send_word(FN_READ, rnd_pix(), rnd_pix(), rnd_pix(), rnd_lanes());
  endtask

  task automatic test_access_codes();
    send_word(FN_READ, 8'h00, 8'h00, 8'h00, 3'b000);
    send_word(FN_COUNT, 8'hff, 8'hff, 8'hff, LANES_ALL);
    send_word(FN_BAD, 8'hff, 8'h00, 8'hff, LANES_ALL);
    send_word(FN_BAD, 8'h00, 8'hff, 8'h00, 3'b000);
    send_word(FN_WRITE, 8'hff, 8'hff, 8'hff, 3'b110);
    send_word(FN_WRITE, 8'hff, 8'hff, 8'hff, 3'b011);
    send_word(FN_WRITE, 8'hff, 8'hff, 8'hff, 3'b101);
    send_word(FN_WRITE, 8'h00, 8'h00, 8'h00, 3'b000);
    wait_drained();
  endtask

  // full-scale red, zero green, alternating bit pattern on blue
  task automatic test_window_extremes();
    for (int t = 0; t < 9; t++) begin
      send_word(FN_WRITE, 8'hff, 8'h00, (t % 2) ? 8'haa : 8'h55, LANES_ALL);
    end
    send_word(FN_COUNT, 8'h00, 8'h00, 8'h00, 3'b000);
    send_reads(3);
    send_word(FN_READ, 8'hff, 8'hff, 8'hff, LANES_ALL);
    wait_drained();
  endtask

  // ninth pixel is refused with fewer than three free slots, then retried
  task automatic test_queue_full();
    send_window(0);
    send_window(0);
    repeat (8) send_word(FN_WRITE, rnd_pix(), rnd_pix(), rnd_pix(), LANES_ALL);
    send_word(FN_WRITE, rnd_pix(), rnd_pix(), rnd_pix(), LANES_ALL);
    send_word(FN_COUNT, rnd_pix(), rnd_pix(), rnd_pix(), rnd_lanes());
    send_reads(1);
    send_word(FN_WRITE, rnd_pix(), rnd_pix(), rnd_pix(), LANES_ALL);
    send_word(FN_COUNT, rnd_pix(), rnd_pix(), rnd_pix(), rnd_lanes());
    send_reads(DEPTH + 1);
    wait_drained();
  endtask

  task automatic test_random_traffic(input int n);
    int start;
    int pick;
    start = words_sent;
    while (words_sent - start < n) begin
      pick = $urandom_range(99);
      if (blur_fifo.size() > DEPTH - 3 && $urandom_range(3) != 0) begin
        send_reads($urandom_range(1, blur_fifo.size()));
      end else if (pick < 55) begin
        send_window(8);
      end else if (pick < 80) begin
        send_reads($urandom_range(1, 5));
      end else if (pick < 87) begin
        send_word(FN_COUNT, rnd_pix(), rnd_pix(), rnd_pix(), rnd_lanes());
      end else if (pick < 97) begin
        send_word(func_t'($urandom_range(3)), rnd_pix(), rnd_pix(), rnd_pix(),
                  rnd_lanes());
      end else begin
        wait_drained();
        send_reads(1);
      end
    end
  endtask

  task automatic test_back_to_back(input int n);
    calm = 1'b1;
    test_random_traffic(n);
    wait_drained();
    calm = 1'b0;
  endtask

  always @(posedge clk) begin
    out_ready <= calm || ($urandom_range(99) >= 31);
  end

  always @(posedge clk) begin
    if (rst_n && out_valid && out_ready) begin
      if (pending_resp.size() == 0) begin
        $display("%0t: unexpected word read_data %0d status %0d", $time, out_read_data,
                 out_status);
        errors++;
      end else begin
        want = pending_resp.pop_front();
        if (out_read_data !== want.data) begin
          $display("%0t: read_data expected %0d got %0d", $time, want.data, out_read_data);
          errors++;
        end
        if (out_status !== want.status) begin
          $display("%0t: status expected %0d got %0d", $time, want.status, out_status);
          errors++;
        end
      end
    end
  end

  initial begin
    tap_idx = '0;
    acc_red = '0;
    acc_green = '0;
    acc_blue = '0;
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_access_codes();
    test_window_extremes();
    test_queue_full();
    test_random_traffic(300);
    wait_drained();
    test_back_to_back(120);
    test_random_traffic(280);
    wait_drained();
    repeat (4) @(posedge clk);

    if (errors == 0) begin
      $display("gaussian_blur_window_rgb verification clean");
    end else begin
      $display("gaussian_blur_window_rgb verification failed");
    end
    $finish;
  end

endmodule
`default_nettype wire
